@@ sv/bdq_pkg.sv @@
// Shared types and constants of the bounded deque with insert.
`default_nettype none

package bdq_pkg;

  // Storage depth; the occupancy, position and limit fields are sized for it
  localparam int unsigned DEPTH  = 16;

  // Fixed field widths
  localparam int unsigned WORD_W = 32;
  localparam int unsigned CAP_W  = 5;
  localparam int unsigned POS_W  = 5;
  localparam int unsigned OCC_W  = 5;
  localparam int unsigned REQ_W  = 3;
  localparam int unsigned STS_W  = 2;

  // Configuration register
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
  localparam logic             REG_CAP   = 1'b0;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_BACK  = 3'd0,
    REQ_PUSH_FRONT = 3'd1,
    REQ_POP_BACK   = 3'd2,
    REQ_POP_FRONT  = 3'd3,
    REQ_CLEAR      = 3'd4,
    REQ_INSERT     = 3'd5
  } req_e;

  typedef enum logic [STS_W-1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2
  } status_e;

  // What the decoded request does to the queue
  typedef enum logic [3:0] {
    OP_NOP,
    OP_FULL,
    OP_EMPTY,
    OP_CLEAR,
    OP_PUSH_BACK,
    OP_PUSH_FRONT,
    OP_POP_BACK,
    OP_POP_FRONT,
    OP_SHIFT
  } op_kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INSERT,
    S_DONE
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic latch;
    logic exec;
    logic shift_rd;
    logic shift_wr;
    logic ins_wr;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_shift;
    logic shift_more;
    logic slot_free;
  } sts_t;

endpackage

`default_nettype wire

@@ sv/bdq_if.sv @@
// Request and response channel interfaces of the deque.
`default_nettype none

interface bdq_req_if
  import bdq_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [POS_W-1:0] position;
  logic [WORD_W-1:0] word_in;

  modport source (output valid, output req_type, output position, output word_in,
                  input ready);
  modport sink   (input valid, input req_type, input position, input word_in,
                  output ready);
endinterface

interface bdq_rsp_if
  import bdq_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] word_out;
  logic              word_valid;
  logic [STS_W-1:0]  status;
  logic [OCC_W-1:0]  occupancy;

  modport source (output valid, output word_out, output word_valid, output status,
                  output occupancy, input ready);
  modport sink   (input valid, input word_out, input word_valid, input status,
                  input occupancy, output ready);
endinterface

`default_nettype wire

@@ sv/bounded_deque_with_insert.sv @@
// Bounded double-ended queue with positional insert: top level.
//
// Requests arrive on the req channel (valid/ready): push back, push front,
// pop back, pop front, clear, or insert at a position from the front. Every
// item gives one result item on the rsp channel carrying the popped word (zero
// when none), a popped flag, a status code and the occupancy after it.
// capacity_limit is written over the APB-style port at address 0; a limit
// above DEPTH acts as DEPTH.
// An item is taken in the idle state, decoded and applied in the decide state,
// and its result is registered in the done state. A middle insert moves each
// entry with a read state then a write state, as the entry store has registered
// read data, and then writes the new word in the insert state.
// The result register holds a finished item while the receiver stalls; the
// block accepts the next request meanwhile and waits before its own result
// until the register is free.
// Reset empties the queue and sets the limit to 16; store contents are left.
`default_nettype none

module bounded_deque_with_insert
  import bdq_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  bdq_req_if.sink          req,
  bdq_rsp_if.source        rsp,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic [CAP_W-1:0] cap_q;
  logic             cap_sel;
  cmd_t             cmd;
  sts_t             sts;

  // Register index is the word address
  assign cap_sel = (paddr[2] == REG_CAP);
  assign pready  = 1'b1;
  assign prdata  = cap_sel ? 32'(cap_q) : '0;

  // Capacity limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (psel && penable && pwrite && cap_sel) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  bdq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req.valid),
    .in_ready_o (req.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bdq_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cap_i        (cap_q),
    .req_type_i   (req.req_type),
    .position_i   (req.position),
    .word_in_i    (req.word_in),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .rsp_ready_i  (rsp.ready),
    .rsp_valid_o  (rsp.valid),
    .word_out_o   (rsp.word_out),
    .word_valid_o (rsp.word_valid),
    .status_o     (rsp.status),
    .occupancy_o  (rsp.occupancy)
  );

endmodule

`default_nettype wire

@@ sv/bdq_ram.sv @@
// Entry store: one write port, one read port with registered read data.
`default_nettype none

module bdq_ram
  import bdq_pkg::*;
#(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = 4
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WORD_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WORD_W-1:0] rdata_o
);

  logic [WORD_W-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ sv/bdq_dp.sv @@
// Datapath: request registers, ring pointers, entry store and result register.
`default_nettype none

module bdq_dp
  import bdq_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [CAP_W-1:0]  cap_i,
  input  wire logic [REQ_W-1:0]  req_type_i,
  input  wire logic [POS_W-1:0]  position_i,
  input  wire logic [WORD_W-1:0] word_in_i,
  input  wire cmd_t              cmd_i,
  output sts_t                   sts_o,
  input  wire logic              rsp_ready_i,
  output logic                   rsp_valid_o,
  output logic      [WORD_W-1:0] word_out_o,
  output logic                   word_valid_o,
  output logic      [STS_W-1:0]  status_o,
  output logic      [OCC_W-1:0]  occupancy_o
);

  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned CMP_A  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int unsigned CMP_W  = (CMP_A > POS_W) ? CMP_A : POS_W;

  // Ring slot of an offset from the head
  function automatic logic [ADDR_W-1:0] slot(input logic [ADDR_W-1:0] h,
                                             input logic [CNT_W-1:0]  off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(h) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(DEPTH)) begin
      sum = sum - (CNT_W+1)'(DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

  req_e              req_q;
  logic [POS_W-1:0]  pos_q;
  logic [WORD_W-1:0] word_q;
  logic [ADDR_W-1:0] head_q, head_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  k_q, k_d;
  status_e           st_q, st_d;
  logic              pop_q, pop_d;
  logic              out_valid_q;

  logic [CMP_W-1:0]  count_x, cap_x, pos_x, kdec_x;
  logic              at_limit;
  op_kind_e          op;

  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [WORD_W-1:0] wdata, rdata;

  // Compare operands at one common width
  assign count_x  = CMP_W'(count_q);
  assign cap_x    = CMP_W'(cap_i);
  assign pos_x    = CMP_W'(pos_q);
  assign kdec_x   = CMP_W'(k_q - CNT_W'(1));
  assign at_limit = (count_x >= cap_x) || (count_q == CNT_W'(DEPTH));

  // Classify the held request
  always_comb begin
    op = OP_NOP;
    unique case (req_q)
      REQ_PUSH_BACK:  op = at_limit ? OP_FULL : OP_PUSH_BACK;
      REQ_PUSH_FRONT: op = at_limit ? OP_FULL : OP_PUSH_FRONT;
      REQ_INSERT: begin
        priority if (at_limit)           op = OP_FULL;
        else if (pos_x >= count_x)       op = OP_PUSH_BACK;
        else if (pos_x == '0)            op = OP_PUSH_FRONT;
        else                             op = OP_SHIFT;
      end
      REQ_POP_BACK:   op = (count_q == '0) ? OP_EMPTY : OP_POP_BACK;
      REQ_POP_FRONT:  op = (count_q == '0) ? OP_EMPTY : OP_POP_FRONT;
      REQ_CLEAR:      op = OP_CLEAR;
      default:        op = OP_NOP;
    endcase
  end

  // Pointer, store and status updates
  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    k_d     = k_q;
    st_d    = st_q;
    pop_d   = pop_q;
    we      = 1'b0;
    waddr   = slot(head_q, count_q);
    wdata   = word_q;
    re      = 1'b0;
    raddr   = slot(head_q, k_q - CNT_W'(1));

    if (cmd_i.exec) begin
      st_d  = STS_OK;
      pop_d = 1'b0;
      unique case (op)
        OP_FULL:  st_d = STS_FULL;
        OP_EMPTY: st_d = STS_EMPTY;
        OP_CLEAR: count_d = '0;
        OP_PUSH_BACK: begin
          we      = 1'b1;
          count_d = count_q + CNT_W'(1);
        end
        OP_PUSH_FRONT: begin
          head_d  = (head_q == '0) ? ADDR_W'(DEPTH - 1) : head_q - ADDR_W'(1);
          we      = 1'b1;
          waddr   = head_d;
          count_d = count_q + CNT_W'(1);
        end
        OP_POP_BACK: begin
          re      = 1'b1;
          raddr   = slot(head_q, count_q - CNT_W'(1));
          pop_d   = 1'b1;
          count_d = count_q - CNT_W'(1);
        end
        OP_POP_FRONT: begin
          re      = 1'b1;
          raddr   = head_q;
          pop_d   = 1'b1;
          head_d  = slot(head_q, CNT_W'(1));
          count_d = count_q - CNT_W'(1);
        end
        OP_SHIFT: k_d = count_q;
        default: ;
      endcase
    end

    // Move one entry back by one slot
    if (cmd_i.shift_rd) begin
      re = 1'b1;
    end
    if (cmd_i.shift_wr) begin
      we    = 1'b1;
      waddr = slot(head_q, k_q);
      wdata = rdata;
      k_d   = k_q - CNT_W'(1);
    end

    // Drop the new word into the opened slot
    if (cmd_i.ins_wr) begin
      we      = 1'b1;
      waddr   = slot(head_q, pos_x[CNT_W-1:0]);
      count_d = count_q + CNT_W'(1);
    end
  end

  bdq_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Capture the accepted item
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q  <= req_e'(req_type_i);
      pos_q  <= position_i;
      word_q <= word_in_i;
    end
    k_q   <= k_d;
    st_q  <= st_d;
    pop_q <= pop_d;
  end

  // Queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // Result register: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      word_out_o   <= pop_q ? rdata : '0;
      word_valid_o <= pop_q;
      status_o     <= st_q;
      occupancy_o  <= count_x[OCC_W-1:0];
    end
  end

  assign rsp_valid_o      = out_valid_q;
  assign sts_o.is_shift   = (op == OP_SHIFT);
  assign sts_o.shift_more = (kdec_x > pos_x);
  assign sts_o.slot_free  = !out_valid_q || rsp_ready_i;

endmodule

`default_nettype wire

@@ sv/bdq_ctrl.sv @@
// Controller: sequences decode, entry shifting and result hand-off.
`default_nettype none

module bdq_ctrl
  import bdq_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  ctrl_state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (in_valid_i) state_d = S_DECIDE;
      S_DECIDE:   state_d = sts_i.is_shift ? S_SHIFT_RD : S_DONE;
      S_SHIFT_RD: state_d = S_SHIFT_WR;
      S_SHIFT_WR: state_d = sts_i.shift_more ? S_SHIFT_RD : S_INSERT;
      S_INSERT:   state_d = S_DONE;
      S_DONE:     if (sts_i.slot_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      S_DECIDE:   cmd_o.exec     = 1'b1;
      S_SHIFT_RD: cmd_o.shift_rd = 1'b1;
      S_SHIFT_WR: cmd_o.shift_wr = 1'b1;
      S_INSERT:   cmd_o.ins_wr   = 1'b1;
      S_DONE:     cmd_o.load_out = sts_i.slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Testbench for the bounded deque with insert: directed table, random traffic, ring predictor.
module tb;
  import bdq_pkg::*;

  localparam int QDEPTH     = 16;
  localparam int IDLE_LIMIT = 2000;
  localparam int RAND_ITEMS = 850;
  localparam int PHASES     = 7;

  // Request codes the block does not define
  localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;
  localparam logic [2:0] CAP_ADDR = 3'(4 * REG_CAP);

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              popped;
    logic [STS_W-1:0]  status;
    logic [OCC_W-1:0]  occ;
  } deque_result_t;

  typedef struct packed {
    logic              is_cfg;
    logic [REQ_W-1:0]  op;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] word;
    logic              typed;
    deque_result_t     want;
  } step_t;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  bdq_req_if req_if ();
  bdq_rsp_if rsp_if ();

  bounded_deque_with_insert u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req     (req_if),
    .rsp     (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predicted ring state and limit
  logic [WORD_W-1:0] ring_word [QDEPTH];
  logic [3:0]        ring_head;
  logic [OCC_W-1:0]  ring_count;
  logic [OCC_W-1:0]  cap_limit;

  deque_result_t pending_results [$];
  step_t         dir_tab [$];
  int            mismatch_count;
  int            results_seen;
  int            sent_count;
  logic          send_quiet;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [3:0] slot_at(input int off);
    return 4'(int'(ring_head) + off);
  endfunction

  // Apply one request to the predicted ring and return its result
  function automatic deque_result_t deque_apply(input logic [REQ_W-1:0] op,
                                                input logic [POS_W-1:0] pos,
                                                input logic [WORD_W-1:0] word);
    deque_result_t res;
    logic [OCC_W-1:0] lim;
    logic adding;
    res = '0;
    res.status = STS_OK;
    lim = (cap_limit > OCC_W'(QDEPTH)) ? OCC_W'(QDEPTH) : cap_limit;
    adding = (op == REQ_PUSH_BACK) || (op == REQ_PUSH_FRONT) || (op == REQ_INSERT);
    if (adding && ring_count >= lim) begin
      res.status = STS_FULL;
    end else if (op == REQ_PUSH_BACK || (op == REQ_INSERT && pos >= ring_count)) begin
      ring_word[slot_at(int'(ring_count))] = word;
      ring_count = ring_count + 1'b1;
    end else if (op == REQ_PUSH_FRONT || (op == REQ_INSERT && pos == '0)) begin
      ring_head = ring_head - 1'b1;
      ring_word[ring_head] = word;
      ring_count = ring_count + 1'b1;
    end else if (op == REQ_INSERT) begin
      // shift the tail back by one to open the slot
      for (int k = int'(ring_count); k > int'(pos); k--)
        ring_word[slot_at(k)] = ring_word[slot_at(k - 1)];
      ring_word[slot_at(int'(pos))] = word;
      ring_count = ring_count + 1'b1;
    end else if (op == REQ_POP_BACK || op == REQ_POP_FRONT) begin
      if (ring_count == '0) begin
        res.status = STS_EMPTY;
      end else if (op == REQ_POP_BACK) begin
        res.word = ring_word[slot_at(int'(ring_count) - 1)];
        res.popped = 1'b1;
        ring_count = ring_count - 1'b1;
      end else begin
        res.word = ring_word[ring_head];
        res.popped = 1'b1;
        ring_head = ring_head + 1'b1;
        ring_count = ring_count - 1'b1;
      end
    end else if (op == REQ_CLEAR) begin
      ring_count = '0;
    end
    res.occ = ring_count;
    return res;
  endfunction

  function automatic step_t row(input logic is_cfg, input logic [REQ_W-1:0] op,
                                input logic [POS_W-1:0] pos, input logic [WORD_W-1:0] word,
                                input logic typed, input logic [WORD_W-1:0] w_word,
                                input logic w_popped, input logic [STS_W-1:0] w_status,
                                input logic [OCC_W-1:0] w_occ);
    step_t s;
    s.is_cfg = is_cfg;
    s.op = op;
    s.pos = pos;
    s.word = word;
    s.typed = typed;
    s.want.word = w_word;
    s.want.popped = w_popped;
    s.want.status = w_status;
    s.want.occ = w_occ;
    return s;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on result %0d: %s got %h want %h", results_seen, what, got, want);
    mismatch_count++;
  endtask

  // Hold the request channel quiet until the block has drained, then write the limit
  task automatic cap_write(input logic [OCC_W-1:0] value);
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    cap_limit = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Offer one item after a drawn gap; predict its result once accepted
  task automatic send_item(input logic [REQ_W-1:0] op, input logic [POS_W-1:0] pos,
                           input logic [WORD_W-1:0] word, input logic typed,
                           input deque_result_t want);
    int gap;
    deque_result_t pred;
    if (sent_count % 32 == 0) send_quiet = ($urandom_range(0, 2) == 0);
    gap = send_quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.req_type <= op;
    req_if.position <= pos;
    req_if.word_in  <= word;
    req_if.valid    <= 1'b1;
    do @(posedge clk_i); while (!(req_if.valid && req_if.ready));
    pred = deque_apply(op, pos, word);
    pending_results.push_back(typed ? want : pred);
    sent_count++;
  endtask

  // Receiver: stall a drawn number of cycles before each item
  initial begin : rsp_side
    int stall;
    int n_rsp;
    logic quiet;
    n_rsp = 0;
    quiet = 1'b0;
    rsp_if.ready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (n_rsp % 32 == 0) quiet = ($urandom_range(0, 2) == 0);
      stall = quiet ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(rsp_if.valid && rsp_if.ready));
      n_rsp++;
    end
  end

  // Check each result against the oldest expectation; watch for a stall
  always @(posedge clk_i) begin : mon
    deque_result_t want;
    int idle_cycles;
    if (!rst_ni) begin
      idle_cycles = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        idle_cycles = 0;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected item, word_out", rsp_if.word_out, '0);
        end else begin
          want = pending_results.pop_front();
          if (rsp_if.word_out !== want.word)
            report_mismatch("word_out", rsp_if.word_out, want.word);
          if (rsp_if.word_valid !== want.popped)
            report_mismatch("word_valid", 32'(rsp_if.word_valid), 32'(want.popped));
          if (rsp_if.status !== want.status)
            report_mismatch("status", 32'(rsp_if.status), 32'(want.status));
          if (rsp_if.occupancy !== want.occ)
            report_mismatch("occupancy", 32'(rsp_if.occupancy), 32'(want.occ));
        end
        results_seen++;
      end else if (req_if.valid && req_if.ready) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin : stim
    deque_result_t none;
    step_t s;
    logic [OCC_W-1:0] phase_cap;
    logic [REQ_W-1:0] op;
    logic [POS_W-1:0] pos;
    logic [WORD_W-1:0] word;
    logic filling;
    int r;
    int per_phase;

    none = '0;
    mismatch_count = 0;
    results_seen = 0;
    sent_count = 0;
    send_quiet = 1'b0;
    filling = 1'b1;
    ring_head = '0;
    ring_count = '0;
    cap_limit = CAP_RESET;
    for (int i = 0; i < QDEPTH; i++) ring_word[i] = '0;

    rst_ni          <= 1'b0;
    req_if.valid    <= 1'b0;
    req_if.req_type <= REQ_PUSH_BACK;
    req_if.position <= '0;
    req_if.word_in  <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: empty pops, spare codes, both ends, inserts, limits
    dir_tab.push_back(row(0, REQ_POP_BACK, 0, 0, 1, 0, 0, STS_EMPTY, 0));
    dir_tab.push_back(row(0, REQ_POP_FRONT, 0, 0, 1, 0, 0, STS_EMPTY, 0));
    dir_tab.push_back(row(0, REQ_SPARE_6, 5'd31, 32'hFFFF_FFFF, 1, 0, 0, STS_OK, 0));
    dir_tab.push_back(row(0, REQ_SPARE_7, 0, 0, 1, 0, 0, STS_OK, 0));
    dir_tab.push_back(row(0, REQ_CLEAR, 0, 0, 1, 0, 0, STS_OK, 0));
    dir_tab.push_back(row(0, REQ_PUSH_BACK, 0, 32'hFFFF_FFFF, 1, 0, 0, STS_OK, 1));
    dir_tab.push_back(row(0, REQ_PUSH_FRONT, 0, 32'h0000_0000, 1, 0, 0, STS_OK, 2));
    dir_tab.push_back(row(0, REQ_INSERT, 0, 32'h1234_5678, 1, 0, 0, STS_OK, 3));
    dir_tab.push_back(row(0, REQ_INSERT, 5'd31, 32'hA5A5_A5A5, 1, 0, 0, STS_OK, 4));
    dir_tab.push_back(row(0, REQ_INSERT, 5'd2, 32'h5A5A_5A5A, 0, 0, 0, STS_OK, 0));
    dir_tab.push_back(row(0, REQ_INSERT, 5'd4, 32'h0000_0001, 0, 0, 0, STS_OK, 0));
    dir_tab.push_back(row(0, REQ_INSERT, 5'd6, 32'h8000_0000, 0, 0, 0, STS_OK, 0));
    dir_tab.push_back(row(0, REQ_POP_FRONT, 0, 0, 1, 32'h1234_5678, 1, STS_OK, 6));
    dir_tab.push_back(row(0, REQ_POP_BACK, 0, 0, 1, 32'h8000_0000, 1, STS_OK, 5));
    dir_tab.push_back(row(0, REQ_POP_BACK, 0, 0, 0, 0, 0, STS_OK, 0));
    dir_tab.push_back(row(0, REQ_POP_FRONT, 0, 0, 0, 0, 0, STS_OK, 0));
    dir_tab.push_back(row(0, REQ_CLEAR, 0, 0, 1, 0, 0, STS_OK, 0));
    dir_tab.push_back(row(1, REQ_PUSH_BACK, 0, 32'd0, 0, 0, 0, STS_OK, 0));
    dir_tab.push_back(row(0, REQ_PUSH_BACK, 0, 32'h0F0F_0F0F, 1, 0, 0, STS_FULL, 0));
    dir_tab.push_back(row(0, REQ_INSERT, 0, 32'hF0F0_F0F0, 1, 0, 0, STS_FULL, 0));
    dir_tab.push_back(row(0, REQ_POP_FRONT, 0, 0, 1, 0, 0, STS_EMPTY, 0));
    dir_tab.push_back(row(1, REQ_PUSH_BACK, 0, 32'd1, 0, 0, 0, STS_OK, 0));
    dir_tab.push_back(row(0, REQ_PUSH_FRONT, 0, 32'h3C3C_C3C3, 1, 0, 0, STS_OK, 1));
    dir_tab.push_back(row(0, REQ_INSERT, 0, 32'h6969_9696, 1, 0, 0, STS_FULL, 1));
    dir_tab.push_back(row(0, REQ_POP_BACK, 0, 0, 1, 32'h3C3C_C3C3, 1, STS_OK, 0));

    foreach (dir_tab[i]) begin
      s = dir_tab[i];
      if (s.is_cfg) cap_write(s.word[OCC_W-1:0]);
      else send_item(s.op, s.pos, s.word, s.typed, s.want);
    end

    // Random phases, each under its own limit; fill and drain in bursts
    per_phase = RAND_ITEMS / PHASES + 1;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: phase_cap = 5'd31;
        1: phase_cap = 5'd16;
        2: phase_cap = 5'd3;
        3: phase_cap = 5'd17;
        4: phase_cap = 5'd0;
        5: phase_cap = 5'($urandom_range(2, 15));
        default: phase_cap = 5'($urandom_range(0, 31));
      endcase
      cap_write(phase_cap);
      for (int n = 0; n < per_phase; n++) begin
        if (n % 20 == 0) filling = ~filling;
        r = $urandom_range(0, 99);
        if (r < 2) begin
          op = ($urandom_range(0, 1) == 0) ? REQ_SPARE_6 : REQ_SPARE_7;
        end else if (r < 4) begin
          op = REQ_CLEAR;
        end else if (r < (filling ? 74 : 32)) begin
          r = $urandom_range(0, 9);
          op = (r < 3) ? REQ_PUSH_BACK : (r < 6) ? REQ_PUSH_FRONT : REQ_INSERT;
        end else begin
          op = ($urandom_range(0, 1) == 0) ? REQ_POP_BACK : REQ_POP_FRONT;
        end
        if (op == REQ_INSERT && $urandom_range(0, 9) < 7)
          pos = 5'($urandom_range(0, int'(ring_count)));
        else
          pos = 5'($urandom_range(0, 31));
        r = $urandom_range(0, 99);
        word = (r < 5) ? 32'h0000_0000 : (r < 10) ? 32'hFFFF_FFFF : 32'($urandom);
        send_item(op, pos, word, 1'b0, none);
      end
    end
    req_if.valid <= 1'b0;

    // Drain, then watch a while longer for stray items
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
